// File: sv/tle_pkg.sv
// Package for the terminal line editor: character codes, FSM states and the result item type.
// Used by the output register and the top level.
`default_nettype none

package tle_pkg;

    localparam int TLE_LINE_DEPTH = 32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic DEST_ECHO = 1'b0;
    localparam logic DEST_SINK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ERASE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic       dest;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

// File: sv/tle_if.sv
// Valid/ready channels of the terminal line editor: received bytes in, result items out.
// No dependencies.
`default_nettype none

interface tle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_res_if;
    logic       valid;
    logic       ready;
    logic       dest;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, output dest, output out_byte, output byte_valid,
                    output last, input ready);
    modport sink   (input valid, input dest, input out_byte, input byte_valid,
                    input last, output ready);
endinterface

`default_nettype wire

// File: sv/tle_line_ram.sv
// Line memory of the terminal line editor: one write port, one read port, registered read.
// Depends on nothing but its parameters.
`default_nettype none

module tle_line_ram #(
    parameter int DEPTH  = 31,
    parameter int ADDR_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]             o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/tle_out_reg.sv
// Output register of the terminal line editor: holds one result item until the sink takes it.
// Depends on tle_pkg and the tle_res_if interface.
`default_nettype none

module tle_out_reg
    import tle_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_item,
    output logic         o_free,
    tle_res_if.source    o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_item;

    assign o_free  = !r_valid || o_res.ready;
    assign n_valid = i_load || (r_valid && !o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.dest       = r_item.dest;
    assign o_res.out_byte   = r_item.out_byte;
    assign o_res.byte_valid = r_item.byte_valid;
    assign o_res.last       = r_item.last;

endmodule

`default_nettype wire

// File: sv/terminal_line_editor.sv
// Terminal line editor: builds a line of up to LINE_DEPTH-1 bytes in a one-port-read line memory.
// An echo or an empty-line marker appears in the cycle after its byte is accepted.
// Erase: backspace, space, backspace. Line end: one byte per cycle while the output register is
// free, after the registered read of the line memory; the next byte is taken once the run is out.
// Reset clears the fill count, the FSM and the output register; the line memory is not cleared.
`default_nettype none

module terminal_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = TLE_LINE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tle_rx_if.sink    i_rx,
    tle_res_if.source o_res
);

    localparam int CAP    = LINE_DEPTH - 1;
    localparam int CNT_W  = $clog2(LINE_DEPTH);
    localparam int ADDR_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAP);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] n_len;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;
    logic [CNT_W-1:0] r_emit_idx;
    logic [CNT_W-1:0] n_emit_idx;
    logic             r_dv;
    logic             n_dv;
    logic             r_step;
    logic             n_step;

    logic       out_free;
    logic       load;
    t_result    item;
    logic       mem_we;
    logic       mem_re;
    logic [7:0] rd_data;
    logic       accept;
    logic       is_eol;
    logic       is_erase;
    logic       emit;
    logic       emit_last;

    assign accept    = i_rx.valid && i_rx.ready;
    assign is_eol    = (i_rx.rx_byte == CH_CR) || (i_rx.rx_byte == CH_LF);
    assign is_erase  = (i_rx.rx_byte == CH_BS) || (i_rx.rx_byte == CH_DEL);
    assign emit      = (r_state == ST_READ) && r_dv && out_free;
    assign emit_last = (CNT_W'(r_emit_idx + 1'b1) == r_len);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (is_eol || is_erase) && (r_count != '0)) begin
                    n_state = is_eol ? ST_READ : ST_ERASE;
                end
            end
            ST_ERASE: begin
                if (out_free && r_step) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (emit && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_rx.ready = 1'b0;
        load       = 1'b0;
        item       = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        n_count    = r_count;
        n_len      = r_len;
        n_idx      = r_idx;
        n_emit_idx = r_emit_idx;
        n_dv       = r_dv;
        n_step     = r_step;
        case (r_state)
            ST_IDLE: begin
                i_rx.ready = out_free;
                if (accept) begin
                    if (is_eol) begin
                        n_count = '0;
                        if (r_count == '0) begin
                            load            = 1'b1;
                            item.dest       = DEST_SINK;
                            item.byte_valid = 1'b0;
                            item.last       = 1'b1;
                        end else begin
                            n_len      = r_count;
                            n_idx      = '0;
                            n_emit_idx = '0;
                            n_dv       = 1'b0;
                        end
                    end else if (is_erase) begin
                        if (r_count != '0) begin
                            n_count         = r_count - 1'b1;
                            n_step          = 1'b0;
                            load            = 1'b1;
                            item.dest       = DEST_ECHO;
                            item.out_byte   = CH_BS;
                            item.byte_valid = 1'b1;
                        end
                    end else if (r_count < CAP_C) begin
                        mem_we          = 1'b1;
                        n_count         = r_count + 1'b1;
                        load            = 1'b1;
                        item.dest       = DEST_ECHO;
                        item.out_byte   = i_rx.rx_byte;
                        item.byte_valid = 1'b1;
                        item.last       = 1'b1;
                    end
                end
            end
            ST_ERASE: begin
                if (out_free) begin
                    load            = 1'b1;
                    n_step          = 1'b1;
                    item.dest       = DEST_ECHO;
                    item.out_byte   = r_step ? CH_BS : CH_SPACE;
                    item.byte_valid = 1'b1;
                    item.last       = r_step;
                end
            end
            ST_READ: begin
                load            = emit;
                item.dest       = DEST_SINK;
                item.out_byte   = rd_data;
                item.byte_valid = 1'b1;
                item.last       = emit_last;
                if (emit) begin
                    n_emit_idx = r_emit_idx + 1'b1;
                end
                // advance the read while the held byte leaves or none is held
                mem_re = (!r_dv || emit) && (r_idx < r_len);
                if (mem_re) begin
                    n_idx = r_idx + 1'b1;
                end
                n_dv = mem_re || (r_dv && !emit);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_idx      <= n_idx;
        r_emit_idx <= n_emit_idx;
        r_step     <= n_step;
    end

    tle_line_ram #(
        .DEPTH  (CAP),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_rx.rx_byte),
        .i_re    (mem_re),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    tle_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_item  (item),
        .o_free  (out_free),
        .o_res   (o_res)
    );

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("fill count beyond capacity");

    a_echo_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_eol && !is_erase && (r_count < CAP_C))
        |=> (o_res.valid && (o_res.dest == DEST_ECHO) && o_res.last))
        else $error("stored byte not echoed");

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_eol) |=> (r_count == '0))
        else $error("line end did not clear the line");

    a_read_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_READ) && r_dv) |-> ((r_emit_idx < r_idx) && (r_idx <= r_len)))
        else $error("line read out of order");

    a_no_input_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_rx.ready)
        else $error("input taken during a run");

endmodule

`default_nettype wire
